@@ rtl/snpcoh_pkg.sv @@
// Shared types and constants for the snoop coherence transition block.
package snpcoh_pkg;

    // Number of caches carried by the request and result fields.
    localparam int unsigned CACHE_SLOTS = 4;

    // Widths of the packed stream payloads.
    localparam int unsigned REQ_BITS  = 15;
    localparam int unsigned REQ_BYTES = (REQ_BITS + 7) / 8;
    localparam int unsigned RES_BITS  = 25;
    localparam int unsigned RES_BYTES = (RES_BITS + 7) / 8;

    // Source index that means no cache acts.
    localparam logic [2:0] SRC_NONE = 3'd4;

    // Line state encoding shared by all three protocols.
    typedef enum logic [2:0] {
        ST_I  = 3'd0,
        ST_S  = 3'd1,
        ST_M  = 3'd2,
        ST_E  = 3'd3,
        ST_SC = 3'd4,
        ST_SM = 3'd5
    } line_state_t;

    // Protocol selector held in the configuration register.
    typedef enum logic [1:0] {
        PROTO_MSI    = 2'd0,
        PROTO_MESI   = 2'd1,
        PROTO_DRAGON = 2'd2
    } protocol_t;

    // Access kind of a request.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Decoded request held in the input register; op sits in the lowest bit.
    typedef struct packed {
        logic [CACHE_SLOTS-1:0][2:0]        line_state;
        logic [1:0]                         requester;
        logic                               op;
    } request_t;

    // Outcome of one bus transaction.
    typedef struct packed {
        logic                               alloc;
        logic                               xfer;
        logic                               rdx;
        logic [2:0]                         interv;
        logic [2:0]                         flush;
        logic [CACHE_SLOTS-1:0]             inval;
        line_state_t [CACHE_SLOTS-1:0]      ns;
    } decision_t;

endpackage

@@ rtl/snoop_coherence_transition.sv @@
// Snoop coherence transition block: request and result registers around the decision logic.
//
// Usage:
//   A request arrives on the s_ channel: the access kind, the requesting
//   processor and the present state of the line in every cache. One result
//   leaves on the m_ channel per request: the new state of every cache, the
//   invalidation mask, the flushing and intervening caches and the BusRdX,
//   cache-transfer and allocate flags.
//   cfg_wr_en/cfg_wr_data write the protocol register (MSI, MESI, Dragon);
//   write it only while no request is in flight.
//   A request passes through the request register and then the result
//   register. Throughput is one request per cycle while m_tready stays high,
//   set by the single pass of the decision logic between them.
//   Reset empties both registers and selects MSI.
//   When the receiver holds m_tready low, the result waits in its register
//   and one more request is still taken into the request register; after
//   that s_tready stays low until the result is taken.
module snoop_coherence_transition #(
    parameter int unsigned CACHE_COUNT = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [1:0]                           cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // op, requester, line_state_0, line_state_1, line_state_2, line_state_3, pad
    input  logic [snpcoh_pkg::REQ_BYTES*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // next_state_0..3, invalidate_mask, flush_source, intervention_source,
    // bus_read_exclusive, cache_transfer, allocate_line, pad
    output logic [snpcoh_pkg::RES_BYTES*8-1:0]   m_tdata
);

    logic [1:0]            protocol_reg;
    snpcoh_pkg::request_t  in_reg;
    logic                  in_valid_reg;
    snpcoh_pkg::decision_t dec;
    snpcoh_pkg::decision_t out_reg;
    logic                  out_valid_reg;
    logic                  advance;
    logic                  s_fire;

    // Protocol register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_reg <= 2'(snpcoh_pkg::PROTO_MSI);
        end else if (cfg_wr_en) begin
            protocol_reg <= cfg_wr_data;
        end
    end

    // Handshake: the request stage moves on whenever the result register frees.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_tdata[snpcoh_pkg::REQ_BITS-1:0];
        end
    end

    // Coherence decision.
    snpcoh_decide #(
        .CACHE_COUNT (CACHE_COUNT)
    ) u_decide (
        .protocol (protocol_reg),
        .req_in   (in_reg),
        .res      (dec)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_reg <= dec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(snpcoh_pkg::RES_BYTES*8 - snpcoh_pkg::RES_BITS){1'b0}}, out_reg};

    // A full pipeline with a stalled receiver must refuse new requests.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("request taken while both stages are full and stalled");

    // BusRdX always leaves the requester holding the line modified.
    a_rdx_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && dec.rdx) |-> (dec.ns[in_reg.requester] == snpcoh_pkg::ST_M))
        else $error("BusRdX without the requester moving to M");

    // The requester is never told to invalidate its own copy.
    a_no_self_inval: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> !dec.inval[in_reg.requester])
        else $error("requester found in the invalidation mask");

    // A result held under stall does not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result changed");

endmodule

@@ rtl/snpcoh_decide.sv @@
// Combinational coherence decision for one request under MSI, MESI or Dragon.
module snpcoh_decide #(
    parameter int unsigned CACHE_COUNT = 4
) (
    input  logic                  [1:0] protocol,
    input  snpcoh_pkg::request_t        req_in,
    output snpcoh_pkg::decision_t       res
);

    localparam int unsigned NC_USED = (CACHE_COUNT > snpcoh_pkg::CACHE_SLOTS) ?
                                      snpcoh_pkg::CACHE_SLOTS : CACHE_COUNT;
    localparam logic [2:0]  NC_USED_W = 3'(NC_USED);
    localparam int unsigned NC = snpcoh_pkg::CACHE_SLOTS;

    snpcoh_pkg::line_state_t [NC-1:0] st;
    snpcoh_pkg::line_state_t          me;
    logic [NC-1:0] s_mask, m_mask, e_mask, sc_mask, sm_mask, oth;
    logic [1:0]    mloc, eloc, smloc, req;
    logic          has_s, has_m, has_e, has_sc, has_sm, own, wr, req_ok;

    // Normalise the incoming states: unused codes and absent caches read as I.
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            if (i < NC_USED && req_in.line_state[i] <= 3'(snpcoh_pkg::ST_SM)) begin
                st[i] = snpcoh_pkg::line_state_t'(req_in.line_state[i]);
            end else begin
                st[i] = snpcoh_pkg::ST_I;
            end
        end
    end

    // Summary of the snooped states; the highest-numbered holder wins.
    always_comb begin
        mloc  = 2'd0;
        eloc  = 2'd0;
        smloc = 2'd0;
        for (int i = 0; i < NC; i++) begin
            s_mask[i]  = (st[i] == snpcoh_pkg::ST_S);
            m_mask[i]  = (st[i] == snpcoh_pkg::ST_M);
            e_mask[i]  = (st[i] == snpcoh_pkg::ST_E);
            sc_mask[i] = (st[i] == snpcoh_pkg::ST_SC);
            sm_mask[i] = (st[i] == snpcoh_pkg::ST_SM);
            oth[i]     = (2'(i) != req_in.requester) && (st[i] != snpcoh_pkg::ST_I);
            if (m_mask[i]) begin
                mloc = 2'(i);
            end
            if (e_mask[i]) begin
                eloc = 2'(i);
            end
            if (sm_mask[i]) begin
                smloc = 2'(i);
            end
        end
    end

    assign req    = req_in.requester;
    assign wr     = (req_in.op == snpcoh_pkg::OP_WRITE);
    assign req_ok = ({1'b0, req} < NC_USED_W);
    assign me     = st[req];
    assign has_s  = |s_mask;
    assign has_m  = |m_mask;
    assign has_e  = |e_mask;
    assign has_sc = |sc_mask;
    assign has_sm = |sm_mask;
    assign own    = (has_e && eloc == req) || (has_m && mloc == req) ||
                    (has_sm && smloc == req);

    // Per-protocol transition of every cache and the resulting bus events.
    always_comb begin
        res        = '0;
        res.ns     = st;
        res.flush  = snpcoh_pkg::SRC_NONE;
        res.interv = snpcoh_pkg::SRC_NONE;
        if (req_ok) begin
            case (protocol)
                snpcoh_pkg::PROTO_MSI: begin
                    if (wr && has_m) begin
                        if (me != snpcoh_pkg::ST_M) begin
                            res.ns[mloc]    = snpcoh_pkg::ST_I;
                            res.inval[mloc] = 1'b1;
                            res.flush       = {1'b0, mloc};
                            res.ns[req]     = snpcoh_pkg::ST_M;
                            res.rdx         = 1'b1;
                            res.alloc       = 1'b1;
                        end
                    end else if (wr && has_s) begin
                        if (me == snpcoh_pkg::ST_S && $onehot(s_mask)) begin
                            res.ns[req] = snpcoh_pkg::ST_M;
                            res.rdx     = 1'b1;
                        end else begin
                            for (int i = 0; i < NC; i++) begin
                                if (oth[i]) begin
                                    res.ns[i] = snpcoh_pkg::ST_I;
                                end
                            end
                            res.inval   = oth;
                            res.alloc   = (me == snpcoh_pkg::ST_I);
                            res.ns[req] = snpcoh_pkg::ST_M;
                            res.rdx     = 1'b1;
                        end
                    end else if (wr) begin
                        res.ns[req] = snpcoh_pkg::ST_M;
                        res.rdx     = 1'b1;
                        res.alloc   = 1'b1;
                    end else if (has_s) begin
                        if (me == snpcoh_pkg::ST_I) begin
                            res.ns[req] = snpcoh_pkg::ST_S;
                            res.alloc   = 1'b1;
                        end
                    end else if (has_m) begin
                        if (me != snpcoh_pkg::ST_M) begin
                            res.ns[mloc] = snpcoh_pkg::ST_S;
                            res.interv   = {1'b0, mloc};
                            res.flush    = {1'b0, mloc};
                            res.ns[req]  = snpcoh_pkg::ST_S;
                            res.alloc    = 1'b1;
                        end
                    end else begin
                        res.ns[req] = snpcoh_pkg::ST_S;
                        res.alloc   = 1'b1;
                    end
                end
                snpcoh_pkg::PROTO_MESI: begin
                    if (wr && has_m) begin
                        if (me != snpcoh_pkg::ST_M) begin
                            res.ns[mloc]    = snpcoh_pkg::ST_I;
                            res.inval[mloc] = 1'b1;
                            res.flush       = {1'b0, mloc};
                            res.ns[req]     = snpcoh_pkg::ST_M;
                            res.xfer        = 1'b1;
                            res.rdx         = 1'b1;
                            res.alloc       = 1'b1;
                        end
                    end else if (wr && (has_s || has_e)) begin
                        if (me != snpcoh_pkg::ST_I && has_e) begin
                            res.ns[req] = snpcoh_pkg::ST_M;
                        end else begin
                            for (int i = 0; i < NC; i++) begin
                                if (oth[i]) begin
                                    res.ns[i] = snpcoh_pkg::ST_I;
                                end
                            end
                            res.inval   = oth;
                            res.ns[req] = snpcoh_pkg::ST_M;
                            if (me == snpcoh_pkg::ST_I) begin
                                res.xfer  = 1'b1;
                                res.rdx   = 1'b1;
                                res.alloc = 1'b1;
                            end
                        end
                    end else if (wr) begin
                        res.ns[req] = snpcoh_pkg::ST_M;
                        res.rdx     = 1'b1;
                        res.alloc   = 1'b1;
                    end else if (has_s || has_e) begin
                        if (me == snpcoh_pkg::ST_I) begin
                            res.ns[req] = snpcoh_pkg::ST_S;
                            res.alloc   = 1'b1;
                            if (has_e) begin
                                res.ns[eloc] = snpcoh_pkg::ST_S;
                                res.interv   = {1'b0, eloc};
                            end
                            res.xfer = 1'b1;
                        end
                    end else if (has_m) begin
                        if (me != snpcoh_pkg::ST_M) begin
                            res.ns[mloc] = snpcoh_pkg::ST_S;
                            res.interv   = {1'b0, mloc};
                            res.flush    = {1'b0, mloc};
                            res.ns[req]  = snpcoh_pkg::ST_S;
                            res.xfer     = 1'b1;
                            res.alloc    = 1'b1;
                        end
                    end else begin
                        res.ns[req] = snpcoh_pkg::ST_E;
                        res.alloc   = 1'b1;
                    end
                end
                snpcoh_pkg::PROTO_DRAGON: begin
                    if (wr) begin
                        if (own) begin
                            if (has_e) begin
                                res.ns[req] = snpcoh_pkg::ST_M;
                            end
                        end else if (has_sc && !has_sm) begin
                            res.alloc   = (me == snpcoh_pkg::ST_I);
                            res.ns[req] = snpcoh_pkg::ST_SM;
                        end else if (has_e) begin
                            res.alloc    = (me == snpcoh_pkg::ST_I);
                            res.ns[eloc] = snpcoh_pkg::ST_SC;
                            res.interv   = {1'b0, eloc};
                            res.ns[req]  = snpcoh_pkg::ST_SM;
                        end else if (has_m) begin
                            res.alloc    = (me == snpcoh_pkg::ST_I);
                            res.ns[mloc] = snpcoh_pkg::ST_SC;
                            res.interv   = {1'b0, mloc};
                            res.flush    = {1'b0, mloc};
                            res.ns[req]  = snpcoh_pkg::ST_SM;
                        end else if (has_sm) begin
                            if (me == snpcoh_pkg::ST_I) begin
                                res.alloc = 1'b1;
                                res.flush = {1'b0, smloc};
                            end
                            res.ns[smloc] = snpcoh_pkg::ST_SC;
                            res.ns[req]   = snpcoh_pkg::ST_SM;
                        end else begin
                            res.alloc   = 1'b1;
                            res.ns[req] = snpcoh_pkg::ST_M;
                        end
                    end else begin
                        if (own || (has_sc && me != snpcoh_pkg::ST_I)) begin
                            // Read hit: nothing moves.
                            res.alloc = 1'b0;
                        end else if (has_e) begin
                            res.alloc    = (me == snpcoh_pkg::ST_I);
                            res.ns[eloc] = snpcoh_pkg::ST_SC;
                            res.interv   = {1'b0, eloc};
                            res.ns[req]  = snpcoh_pkg::ST_SC;
                        end else if (has_m) begin
                            res.alloc    = (me == snpcoh_pkg::ST_I);
                            res.ns[mloc] = snpcoh_pkg::ST_SM;
                            res.interv   = {1'b0, mloc};
                            res.flush    = {1'b0, mloc};
                            res.ns[req]  = snpcoh_pkg::ST_SC;
                        end else if (has_sm && me == snpcoh_pkg::ST_I) begin
                            res.alloc   = 1'b1;
                            res.flush   = {1'b0, smloc};
                            res.ns[req] = snpcoh_pkg::ST_SC;
                        end else if (has_sc) begin
                            res.alloc   = (me == snpcoh_pkg::ST_I);
                            res.ns[req] = snpcoh_pkg::ST_SC;
                        end else begin
                            res.alloc   = 1'b1;
                            res.ns[req] = snpcoh_pkg::ST_E;
                        end
                    end
                end
                default: begin
                    // Unused protocol code leaves the line untouched.
                    res.alloc = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ verif/snpcoh_checker.sv @@
// Checker for the snoop coherence block: watches both streams, predicts each result and compares.
`timescale 1ns / 100ps

module snpcoh_checker #(
    parameter int unsigned CACHE_COUNT = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          outstanding,
    output int          errors
);

    // Only four caches travel in the fields, so a larger count acts as four.
    localparam int CACHES_USED = (CACHE_COUNT > 4) ? 4 : CACHE_COUNT;

    snpcoh_pkg::decision_t expected_q[$];
    logic [1:0]            protocol_sel;
    int                    fail_count;

    assign errors = fail_count;

    // Every copy except the requester's goes to I and is told to invalidate.
    function automatic snpcoh_pkg::decision_t drop_other_copies(snpcoh_pkg::decision_t r,
                                                                int req);
        for (int i = 0; i < CACHES_USED; i++) begin
            if (i != req && r.ns[i] != snpcoh_pkg::ST_I) begin
                r.ns[i] = snpcoh_pkg::ST_I;
                r.inval[i] = 1'b1;
            end
        end
        return r;
    endfunction

    // Works out the bus transaction outcome for one request under the selected protocol.
    function automatic snpcoh_pkg::decision_t resolve_snoop(logic [1:0] proto, logic wr,
                                                            logic [1:0] req,
                                                            logic [3:0][2:0] st);
        snpcoh_pkg::decision_t   r;
        snpcoh_pkg::line_state_t me;
        bit                      has_s, has_m, has_e, has_sc, has_sm, own;
        int                      num_s, mloc, eloc, smloc;

        has_s = 0; has_m = 0; has_e = 0; has_sc = 0; has_sm = 0;
        num_s = 0; mloc = 0; eloc = 0; smloc = 0;
        r.inval  = '0;
        r.flush  = snpcoh_pkg::SRC_NONE;
        r.interv = snpcoh_pkg::SRC_NONE;
        r.rdx    = 1'b0;
        r.xfer   = 1'b0;
        r.alloc  = 1'b0;

        // Spare codes and absent caches read as I.
        for (int i = 0; i < 4; i++)
            r.ns[i] = snpcoh_pkg::line_state_t'(
                (i < CACHES_USED && st[i] <= snpcoh_pkg::ST_SM) ? st[i] : snpcoh_pkg::ST_I);

        if (int'(req) >= CACHES_USED || proto > snpcoh_pkg::PROTO_DRAGON)
            return r;

        // The highest-numbered holder of an owning state is the one that acts.
        for (int i = 0; i < CACHES_USED; i++) begin
            case (r.ns[i])
                snpcoh_pkg::ST_S:  begin has_s = 1; num_s++; end
                snpcoh_pkg::ST_M:  begin has_m = 1; mloc = i; end
                snpcoh_pkg::ST_E:  begin has_e = 1; eloc = i; end
                snpcoh_pkg::ST_SC: has_sc = 1;
                snpcoh_pkg::ST_SM: begin has_sm = 1; smloc = i; end
                default: ;
            endcase
        end
        me = r.ns[req];

        case (proto)
            snpcoh_pkg::PROTO_MSI: begin
                if (wr && has_m) begin
                    if (me != snpcoh_pkg::ST_M) begin
                        r.ns[mloc] = snpcoh_pkg::ST_I;
                        r.inval[mloc] = 1'b1;
                        r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_M;
                        r.rdx = 1'b1; r.alloc = 1'b1;
                    end
                end else if (wr && has_s) begin
                    if (me == snpcoh_pkg::ST_S && num_s == 1) begin
                        r.ns[req] = snpcoh_pkg::ST_M;
                        r.rdx = 1'b1;
                    end else begin
                        r = drop_other_copies(r, req);
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[req] = snpcoh_pkg::ST_M;
                        r.rdx = 1'b1;
                    end
                end else if (wr) begin
                    r.ns[req] = snpcoh_pkg::ST_M;
                    r.rdx = 1'b1; r.alloc = 1'b1;
                end else if (has_s) begin
                    if (me == snpcoh_pkg::ST_I) begin
                        r.ns[req] = snpcoh_pkg::ST_S;
                        r.alloc = 1'b1;
                    end
                end else if (has_m) begin
                    if (me != snpcoh_pkg::ST_M) begin
                        r.ns[mloc] = snpcoh_pkg::ST_S;
                        r.interv = 3'(mloc); r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_S;
                        r.alloc = 1'b1;
                    end
                end else begin
                    r.ns[req] = snpcoh_pkg::ST_S;
                    r.alloc = 1'b1;
                end
            end
            snpcoh_pkg::PROTO_MESI: begin
                if (wr && has_m) begin
                    if (me != snpcoh_pkg::ST_M) begin
                        r.ns[mloc] = snpcoh_pkg::ST_I;
                        r.inval[mloc] = 1'b1;
                        r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_M;
                        r.xfer = 1'b1; r.rdx = 1'b1; r.alloc = 1'b1;
                    end
                end else if (wr && (has_s || has_e)) begin
                    if (me != snpcoh_pkg::ST_I && has_e) begin
                        r.ns[req] = snpcoh_pkg::ST_M;
                    end else if (me != snpcoh_pkg::ST_I) begin
                        r = drop_other_copies(r, req);
                        r.ns[req] = snpcoh_pkg::ST_M;
                    end else begin
                        r = drop_other_copies(r, req);
                        r.ns[req] = snpcoh_pkg::ST_M;
                        r.xfer = 1'b1; r.rdx = 1'b1; r.alloc = 1'b1;
                    end
                end else if (wr) begin
                    r.ns[req] = snpcoh_pkg::ST_M;
                    r.rdx = 1'b1; r.alloc = 1'b1;
                end else if (has_s || has_e) begin
                    if (me == snpcoh_pkg::ST_I) begin
                        r.ns[req] = snpcoh_pkg::ST_S;
                        r.alloc = 1'b1;
                        if (has_e) begin
                            r.ns[eloc] = snpcoh_pkg::ST_S;
                            r.interv = 3'(eloc);
                        end
                        r.xfer = 1'b1;
                    end
                end else if (has_m) begin
                    if (me != snpcoh_pkg::ST_M) begin
                        r.ns[mloc] = snpcoh_pkg::ST_S;
                        r.interv = 3'(mloc); r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_S;
                        r.xfer = 1'b1; r.alloc = 1'b1;
                    end
                end else begin
                    r.ns[req] = snpcoh_pkg::ST_E;
                    r.alloc = 1'b1;
                end
            end
            default: begin
                // Dragon update protocol.
                own = (has_e && eloc == req) || (has_m && mloc == req) ||
                      (has_sm && smloc == req);
                if (wr) begin
                    if (own) begin
                        if (has_e) r.ns[req] = snpcoh_pkg::ST_M;
                    end else if (has_sc && !has_sm) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[req] = snpcoh_pkg::ST_SM;
                    end else if (has_e) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[eloc] = snpcoh_pkg::ST_SC;
                        r.interv = 3'(eloc);
                        r.ns[req] = snpcoh_pkg::ST_SM;
                    end else if (has_m) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[mloc] = snpcoh_pkg::ST_SC;
                        r.interv = 3'(mloc); r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_SM;
                    end else if (has_sm) begin
                        if (me == snpcoh_pkg::ST_I) begin
                            r.alloc = 1'b1;
                            r.flush = 3'(smloc);
                        end
                        r.ns[smloc] = snpcoh_pkg::ST_SC;
                        r.ns[req] = snpcoh_pkg::ST_SM;
                    end else begin
                        r.alloc = 1'b1;
                        r.ns[req] = snpcoh_pkg::ST_M;
                    end
                end else begin
                    if (own || (has_sc && me != snpcoh_pkg::ST_I)) begin
                        // Read hit: nothing moves.
                    end else if (has_e) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[eloc] = snpcoh_pkg::ST_SC;
                        r.interv = 3'(eloc);
                        r.ns[req] = snpcoh_pkg::ST_SC;
                    end else if (has_m) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[mloc] = snpcoh_pkg::ST_SM;
                        r.interv = 3'(mloc); r.flush = 3'(mloc);
                        r.ns[req] = snpcoh_pkg::ST_SC;
                    end else if (has_sm && me == snpcoh_pkg::ST_I) begin
                        r.alloc = 1'b1;
                        r.flush = 3'(smloc);
                        r.ns[req] = snpcoh_pkg::ST_SC;
                    end else if (has_sc) begin
                        if (me == snpcoh_pkg::ST_I) r.alloc = 1'b1;
                        r.ns[req] = snpcoh_pkg::ST_SC;
                    end else begin
                        r.alloc = 1'b1;
                        r.ns[req] = snpcoh_pkg::ST_E;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Track the protocol, queue predictions for accepted requests and check each result.
    always @(posedge aclk) begin
        snpcoh_pkg::decision_t want, got;
        if (!aresetn) begin
            protocol_sel = snpcoh_pkg::PROTO_MSI;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (cfg_wr_en)
                protocol_sel = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_q.push_back(resolve_snoop(protocol_sel, s_tdata[0], s_tdata[2:1],
                                                   s_tdata[14:3]));
            if (m_tvalid && m_tready) begin
                got = snpcoh_pkg::decision_t'(m_tdata[24:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        check_field($sformatf("next_state_%0d", i), want.ns[i], got.ns[i]);
                    check_field("invalidate_mask", want.inval, got.inval);
                    check_field("flush_source", want.flush, got.flush);
                    check_field("intervention_source", want.interv, got.interv);
                    check_field("bus_read_exclusive", want.rdx, got.rdx);
                    check_field("cache_transfer", want.xfer, got.xfer);
                    check_field("allocate_line", want.alloc, got.alloc);
                end
            end
        end
        outstanding <= expected_q.size();
    end

endmodule

@@ verif/tb.sv @@
// Testbench top for the snoop coherence block: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int          CACHES       = 4;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          RANDOM_ITEMS = 135;
    localparam int          DIRECTED_N   = 6;
    localparam int          PHASES       = 11;
    localparam logic [1:0]  PROTO_SPARE  = 2'd3;
    localparam logic [2:0]  CODE_SPARE_LO = 3'd6;
    localparam logic [2:0]  CODE_SPARE_HI = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          outstanding;
    int          errors;
    int          idle_cycles = 0;

    // The first four phases send only the directed requests, one phase per protocol setting.
    logic [1:0] phase_proto [PHASES] = '{snpcoh_pkg::PROTO_MSI, snpcoh_pkg::PROTO_MESI,
                                         snpcoh_pkg::PROTO_DRAGON, PROTO_SPARE,
                                         snpcoh_pkg::PROTO_MESI, snpcoh_pkg::PROTO_DRAGON,
                                         snpcoh_pkg::PROTO_MSI, snpcoh_pkg::PROTO_DRAGON,
                                         snpcoh_pkg::PROTO_MESI, PROTO_SPARE,
                                         snpcoh_pkg::PROTO_MSI};

    snoop_coherence_transition #(.CACHE_COUNT(CACHES)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    snpcoh_checker #(.CACHE_COUNT(CACHES)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .outstanding(outstanding),
        .errors     (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Packs a request as op, requester, then the line state of caches 0 to 3.
    function automatic logic [15:0] pack_request(logic op, logic [1:0] req, logic [2:0] s0,
                                                 logic [2:0] s1, logic [2:0] s2, logic [2:0] s3);
        return {1'b0, s3, s2, s1, s0, req, op};
    endfunction

    // Corner requests: empty line, several owners, spare codes and foreign states.
    function automatic logic [15:0] directed_request(int k);
        case (k)
            0:       return pack_request(snpcoh_pkg::OP_READ, 2'd0, snpcoh_pkg::ST_I,
                                         snpcoh_pkg::ST_I, snpcoh_pkg::ST_I, snpcoh_pkg::ST_I);
            1:       return pack_request(snpcoh_pkg::OP_WRITE, 2'd3, snpcoh_pkg::ST_I,
                                         snpcoh_pkg::ST_I, snpcoh_pkg::ST_I, snpcoh_pkg::ST_I);
            2:       return pack_request(snpcoh_pkg::OP_WRITE, 2'd0, snpcoh_pkg::ST_I,
                                         snpcoh_pkg::ST_M, snpcoh_pkg::ST_I, snpcoh_pkg::ST_M);
            3:       return pack_request(snpcoh_pkg::OP_READ, 2'd2, CODE_SPARE_LO,
                                         CODE_SPARE_HI, snpcoh_pkg::ST_E, snpcoh_pkg::ST_S);
            4:       return pack_request(snpcoh_pkg::OP_WRITE, 2'd1, snpcoh_pkg::ST_SM,
                                         snpcoh_pkg::ST_SC, snpcoh_pkg::ST_SC, snpcoh_pkg::ST_E);
            default: return pack_request(snpcoh_pkg::OP_READ, 2'd3, snpcoh_pkg::ST_SM,
                                         snpcoh_pkg::ST_E, CODE_SPARE_HI, snpcoh_pkg::ST_SM);
        endcase
    endfunction

    // Mostly line states that the protocol can reach, with random noise mixed in.
    function automatic logic [15:0] random_request(logic [1:0] proto);
        logic [3:0][2:0] st;
        int              kind, holder;
        kind = $urandom_range(0, 9);
        holder = $urandom_range(0, 3);
        st = '0;
        if (kind >= 8 || proto == PROTO_SPARE) begin
            for (int i = 0; i < 4; i++) st[i] = 3'($urandom_range(0, 7));
        end else if (proto == snpcoh_pkg::PROTO_MSI) begin
            if (kind < 3) st[holder] = snpcoh_pkg::ST_M;
            else if (kind < 7)
                for (int i = 0; i < 4; i++)
                    st[i] = $urandom_range(0, 1) ? snpcoh_pkg::ST_S : snpcoh_pkg::ST_I;
        end else if (proto == snpcoh_pkg::PROTO_MESI) begin
            if (kind < 2) st[holder] = snpcoh_pkg::ST_M;
            else if (kind < 4) st[holder] = snpcoh_pkg::ST_E;
            else if (kind < 7)
                for (int i = 0; i < 4; i++)
                    st[i] = $urandom_range(0, 1) ? snpcoh_pkg::ST_S : snpcoh_pkg::ST_I;
        end else begin
            if (kind == 0) st[holder] = snpcoh_pkg::ST_M;
            else if (kind == 1) st[holder] = snpcoh_pkg::ST_E;
            else if (kind < 6) begin
                for (int i = 0; i < 4; i++)
                    st[i] = $urandom_range(0, 1) ? snpcoh_pkg::ST_SC : snpcoh_pkg::ST_I;
                if (kind < 4) st[holder] = snpcoh_pkg::ST_SM;
            end
        end
        return pack_request(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                            st[0], st[1], st[2], st[3]);
    endfunction

    // Mostly back-to-back, some short gaps and a few long ones.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Offers one request and holds it until the block takes it.
    task automatic send_request(logic [15:0] data, bit calm);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = calm ? 0 : sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Waits until every predicted result has been taken.
    task automatic drain_results();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Request side: reset, then per phase a protocol write followed by requests.
    initial begin
        int n;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= snpcoh_pkg::PROTO_MSI;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        n = 0;
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            repeat (2) @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_proto[p];
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            if (p < 4) begin
                for (int k = 0; k < DIRECTED_N; k++)
                    send_request(directed_request(k), 1'b0);
            end else begin
                for (int k = 0; k < RANDOM_ITEMS; k++) begin
                    send_request(random_request(phase_proto[p]), ((n / 50) % 4) == 1);
                    n++;
                end
            end
            s_tvalid <= 1'b0;
        end
        drain_results();
        repeat (4) @(posedge aclk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Result side: random back-pressure, calm stretches and a long hold after 150 results, then every 400 more.
    initial begin
        int taken, hold, next_long, cycle;
        taken = 0; hold = 0; next_long = 150; cycle = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (m_tvalid && m_tready) taken++;
            if (hold == 0) begin
                if (taken >= next_long) begin
                    hold = 120;
                    next_long += 400;
                end else if (((cycle / 200) % 3) != 0 && $urandom_range(0, 3) == 0) begin
                    hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25)
                                                       : $urandom_range(1, 3);
                end
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no request or result moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
